// ===== hdl/ede_pkg.sv =====
package ede_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_BEGIN = 2'd1,
        REQ_CUR   = 2'd2,
        REQ_END   = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        KIND_CHANGED = 2'd0,
        KIND_REMOVED = 2'd1,
        KIND_TRAILER = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] entity_id;
        logic [63:0] motion_word_0;
        logic [63:0] motion_word_1;
        logic [63:0] motion_word_2;
        logic [63:0] motion_word_3;
        logic [63:0] motion_word_4;
        logic [31:0] entity_bits;
        logic [31:0] snapshot_tick;
        logic [31:0] reference_tick;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [31:0] out_id;
        logic [63:0] out_motion_0;
        logic [63:0] out_motion_1;
        logic [63:0] out_motion_2;
        logic [63:0] out_motion_3;
        logic [63:0] out_motion_4;
        logic [31:0] out_bits;
        logic [15:0] changed_total;
        logic [15:0] removed_total;
        logic [63:0] tick_pair;
        logic        run_last;
    } out_item_t;

    // One table row: id, five motion words and flag word
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] m0;
        logic [63:0] m1;
        logic [63:0] m2;
        logic [63:0] m3;
        logic [63:0] m4;
        logic [31:0] bits;
    } ref_row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EMIT,
        ST_WAIT
    } ctl_state_t;

endpackage

// ===== hdl/ede_table.sv =====
module ede_table #(
    parameter int DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  ede_pkg::ref_row_t         wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output ede_pkg::ref_row_t         rd_data
);
    import ede_pkg::*;

    ref_row_t mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/entity_delta_encoder_unit.sv =====
// Load and begin items give no result; the next item is taken the cycle after.
// Current record: table read in ST_READ, compare in ST_CMP; each removed id ahead of it
// takes read, compare and release; the changed record is registered out at its compare.
// End item: each flushed id is read, compared, sent; then the trailer. Current and end items
// wait for their last transfer out, plus any output stall; one item is in work at a time.
// rst_n (async, active low) clears fill, cursor, counters, ticks and mode; table undefined.
module entity_delta_encoder_unit #(
    parameter int MAX_ENTITIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ede_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ede_pkg::out_item_t  out_data
);
    import ede_pkg::*;

    localparam int AW = $clog2(MAX_ENTITIES);
    localparam int CW = $clog2(MAX_ENTITIES + 1);

    ctl_state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [15:0] chg_reg, chg_next, rem_reg, rem_next;
    logic [31:0] stick_reg, stick_next, rtick_reg, rtick_next;
    logic delta_reg, delta_next;
    logic hold_reg, hold_next;
    in_item_t item_reg, item_next;
    out_item_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;
    logic [CW-1:0] rd_ptr;

    logic tbl_we;
    ref_row_t wr_row, rd_row;
    logic accept, out_take, more, same, is_end;
    logic id_hit, skip, drop;

    assign accept   = in_valid && !in_stall;
    assign out_take = ovalid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;

    assign tbl_we = accept && (in_data.req_type == REQ_LOAD)
                    && (fill_reg < CW'(MAX_ENTITIES));
    assign wr_row = '{id: in_data.entity_id, m0: in_data.motion_word_0,
                      m1: in_data.motion_word_1, m2: in_data.motion_word_2,
                      m3: in_data.motion_word_3, m4: in_data.motion_word_4,
                      bits: in_data.entity_bits};

    assign rd_ptr = (cursor_reg < CW'(MAX_ENTITIES)) ? cursor_reg : '0;

    ede_table #(.DEPTH(MAX_ENTITIES)) u_table (
        .clk    (clk),
        .wr_en  (tbl_we),
        .wr_addr(fill_reg[AW-1:0]),
        .wr_data(wr_row),
        .rd_addr(rd_ptr[AW-1:0]),
        .rd_data(rd_row)
    );

    assign more   = delta_reg && (cursor_reg < fill_reg);
    assign is_end = (item_reg.req_type == REQ_END);
    assign same   = (rd_row.m0 == item_reg.motion_word_0)
                 && (rd_row.m1 == item_reg.motion_word_1)
                 && (rd_row.m2 == item_reg.motion_word_2)
                 && (rd_row.m3 == item_reg.motion_word_3)
                 && (rd_row.m4 == item_reg.motion_word_4)
                 && (rd_row.bits == item_reg.entity_bits);
    assign id_hit = more && (rd_row.id == item_reg.entity_id);
    assign skip   = id_hit && same;
    assign drop   = more && (is_end || rd_row.id < item_reg.entity_id);

    // Control state and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            cursor_reg <= '0;
            chg_reg    <= '0;
            rem_reg    <= '0;
            stick_reg  <= '0;
            rtick_reg  <= '0;
            delta_reg  <= 1'b0;
            hold_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cursor_reg <= cursor_next;
            chg_reg    <= chg_next;
            rem_reg    <= rem_next;
            stick_reg  <= stick_next;
            rtick_reg  <= rtick_next;
            delta_reg  <= delta_next;
            hold_reg   <= hold_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        obuf_reg <= obuf_next;
    end

    // Merge sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cursor_next = cursor_reg;
        chg_next    = chg_reg;
        rem_next    = rem_reg;
        stick_next  = stick_reg;
        rtick_next  = rtick_reg;
        delta_next  = delta_reg;
        hold_next   = hold_reg;
        item_next   = item_reg;
        obuf_next   = obuf_reg;
        ovalid_next = ovalid_reg && !out_take;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    unique case (req_kind_t'(in_data.req_type))
                        REQ_LOAD:
                        begin
                            if (tbl_we)
                            begin
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        REQ_BEGIN:
                        begin
                            stick_next  = in_data.snapshot_tick;
                            rtick_next  = in_data.reference_tick;
                            delta_next  = (in_data.reference_tick != '0);
                            cursor_next = '0;
                            chg_next    = '0;
                            rem_next    = '0;
                        end
                        default:
                        begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            // Table read for the row under the cursor is in flight
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_WAIT;
                obuf_next  = '0;
                if (ovalid_reg && out_stall)
                begin
                    state_next = ST_CMP;
                end
                else if (hold_reg)
                begin
                    // Held removed id goes out; it ends the run when the next row is skipped
                    obuf_next   = obuf_reg;
                    ovalid_next = 1'b1;
                    hold_next   = 1'b0;
                    if (skip)
                    begin
                        obuf_next.run_last = 1'b1;
                        cursor_next = cursor_reg + CW'(1);
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
                else if (drop)
                begin
                    // Removed id; for a current record it waits for the next compare
                    obuf_next.out_kind = KIND_REMOVED;
                    obuf_next.out_id   = rd_row.id;
                    ovalid_next = is_end;
                    hold_next   = !is_end;
                    rem_next    = rem_reg + 16'd1;
                    cursor_next = cursor_reg + CW'(1);
                    state_next  = ST_READ;
                end
                else if (is_end)
                begin
                    obuf_next.out_kind      = KIND_TRAILER;
                    obuf_next.changed_total = chg_reg;
                    obuf_next.removed_total = rem_reg;
                    obuf_next.tick_pair     = {stick_reg, rtick_reg};
                    obuf_next.run_last      = 1'b1;
                    ovalid_next = 1'b1;
                    fill_next   = '0;
                    cursor_next = '0;
                    delta_next  = 1'b0;
                    chg_next    = '0;
                    rem_next    = '0;
                end
                else
                begin
                    if (id_hit)
                    begin
                        cursor_next = cursor_reg + CW'(1);
                    end
                    if (!skip)
                    begin
                        obuf_next.out_kind     = KIND_CHANGED;
                        obuf_next.out_id       = item_reg.entity_id;
                        obuf_next.out_motion_0 = item_reg.motion_word_0;
                        obuf_next.out_motion_1 = item_reg.motion_word_1;
                        obuf_next.out_motion_2 = item_reg.motion_word_2;
                        obuf_next.out_motion_3 = item_reg.motion_word_3;
                        obuf_next.out_motion_4 = item_reg.motion_word_4;
                        obuf_next.out_bits     = item_reg.entity_bits;
                        obuf_next.run_last     = 1'b1;
                        ovalid_next = 1'b1;
                        chg_next    = chg_reg + 16'd1;
                    end
                    else
                    begin
                        // Identical record: nothing to send
                        obuf_next = obuf_reg;
                    end
                end
                if (state_next == ST_CMP)
                begin
                    obuf_next = obuf_reg;
                end
            end
            // Hold off the next item until the last result is taken
            ST_WAIT:
            begin
                if (!ovalid_reg || out_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ede_checker.sv =====
module ede_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input ede_pkg::out_item_t  out_data
);
    import ede_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A trailer always closes its run
    a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_kind == KIND_TRAILER |-> out_data.run_last)
        else $error("trailer without run_last");

    // Input is held off while a result is pending
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // A stalled input transfer stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input dropped while stalled");

    // Only valid kinds appear
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_kind == KIND_CHANGED
                       || out_data.out_kind == KIND_REMOVED
                       || out_data.out_kind == KIND_TRAILER))
        else $error("bad result kind");

endmodule

bind entity_delta_encoder_unit ede_checker u_ede_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
